FILE: rtl/aatrm_pkg.sv
// Shared types and constants for the axis-angle to rotation matrix pipeline.
`default_nettype none
package aatrm_pkg;

    // CORDIC depth, limited to the size of the arctangent table
    localparam int CORDIC_STAGES = 14;
    localparam int ATAN_LEN      = 24;
    localparam int N_STAGES      = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
    localparam int SHIFT_W       = $clog2(ATAN_LEN);

    localparam int FW = 16;   // field width
    localparam int XW = 33;   // CORDIC x/y, Q30 plus headroom
    localparam int ZW = 34;   // angle accumulator, 2^32 per turn plus headroom
    localparam int QW = 28;   // quaternion terms, Q24 plus headroom

    localparam logic signed [XW-1:0] GAIN_Q30 = XW'(652032874);

    localparam logic signed [ZW-1:0] ATAN_TBL [ATAN_LEN] = '{
        ZW'(536870912), ZW'(316933406), ZW'(167458907), ZW'(85004756),
        ZW'(42667331),  ZW'(21354465),  ZW'(10679838),  ZW'(5340245),
        ZW'(2670163),   ZW'(1335087),   ZW'(667544),    ZW'(333772),
        ZW'(166886),    ZW'(83443),     ZW'(41722),     ZW'(20861),
        ZW'(10430),     ZW'(5215),      ZW'(2608),      ZW'(1304),
        ZW'(652),       ZW'(326),       ZW'(163),       ZW'(81)
    };

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic signed [FW-1:0] ax;
        logic signed [FW-1:0] ay;
        logic signed [FW-1:0] az;
    } t_cordic;

    typedef struct packed {
        logic signed [QW-1:0] w;
        logic signed [QW-1:0] x;
        logic signed [QW-1:0] y;
        logic signed [QW-1:0] z;
    } t_quat;

    // entry 0 (m00) in the low bits, row by row
    typedef logic [8:0][FW-1:0] t_mat;

endpackage
`default_nettype wire

FILE: rtl/aatrm_cordic_cell.sv
// One rotation-mode CORDIC micro-rotation with its own pipeline register.
`default_nettype none
module aatrm_cordic_cell (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [aatrm_pkg::SHIFT_W-1:0]   i_shift,
    input  wire logic signed [aatrm_pkg::ZW-1:0] i_atan,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire aatrm_pkg::t_cordic              i_data,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output aatrm_pkg::t_cordic                   o_data
);
    import aatrm_pkg::*;

    logic    r_vld;
    t_cordic r_data;
    t_cordic n_data;
    logic    adv;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;

    assign adv     = !r_vld || i_ready;
    assign o_ready = adv;
    assign o_valid = r_vld;
    assign o_data  = r_data;

    always_comb begin
        dx     = i_data.y >>> i_shift;
        dy     = i_data.x >>> i_shift;
        n_data = i_data;
        if (!i_data.z[ZW-1]) begin
            n_data.x = i_data.x - dx;
            n_data.y = i_data.y + dy;
            n_data.z = i_data.z - i_atan;
        end else begin
            n_data.x = i_data.x + dx;
            n_data.y = i_data.y - dy;
            n_data.z = i_data.z + i_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (adv) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_valid) begin
            r_data <= n_data;
        end
    end

`ifndef SYNTHESIS
    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && !i_ready |=> r_vld && $stable(r_data))
        else $error("cordic cell lost a held request");
`endif

endmodule
`default_nettype wire

FILE: rtl/aatrm_quat.sv
// Quaternion forming: w from the cosine, x/y/z from sine times axis, two stages.
`default_nettype none
module aatrm_quat (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire aatrm_pkg::t_cordic i_data,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output aatrm_pkg::t_quat        o_data
);
    import aatrm_pkg::*;

    localparam int PW = XW + FW;

    logic r_vld_a;
    logic r_vld_b;
    logic adv_a;
    logic adv_b;

    logic signed [QW-1:0] r_w_a;
    logic signed [PW-1:0] r_px;
    logic signed [PW-1:0] r_py;
    logic signed [PW-1:0] r_pz;
    t_quat                r_q;

    logic signed [XW-1:0] w_round;
    logic signed [PW-1:0] n_px;
    logic signed [PW-1:0] n_py;
    logic signed [PW-1:0] n_pz;
    t_quat                n_q;

    localparam logic signed [XW-1:0] W_HALF = XW'(32);
    localparam logic signed [PW-1:0] P_HALF = PW'(1) <<< 19;

    assign adv_b   = !r_vld_b || i_ready;
    assign adv_a   = !r_vld_a || adv_b;
    assign o_ready = adv_a;
    assign o_valid = r_vld_b;
    assign o_data  = r_q;

    always_comb begin
        w_round = (i_data.x + W_HALF) >>> 6;
        n_px    = PW'(i_data.y) * PW'(i_data.ax);
        n_py    = PW'(i_data.y) * PW'(i_data.ay);
        n_pz    = PW'(i_data.y) * PW'(i_data.az);
        n_q.w   = r_w_a;
        n_q.x   = QW'((r_px + P_HALF) >>> 20);
        n_q.y   = QW'((r_py + P_HALF) >>> 20);
        n_q.z   = QW'((r_pz + P_HALF) >>> 20);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            if (adv_a) begin
                r_vld_a <= i_valid;
            end
            if (adv_b) begin
                r_vld_b <= r_vld_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_a && i_valid) begin
            r_w_a <= QW'(w_round);
            r_px  <= n_px;
            r_py  <= n_py;
            r_pz  <= n_pz;
        end
        if (adv_b && r_vld_a) begin
            r_q <= n_q;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/aatrm_matrix.sv
// Matrix entries from the quaternion: products, terms, then round and saturate.
`default_nettype none
module aatrm_matrix (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire aatrm_pkg::t_quat i_data,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output aatrm_pkg::t_mat       o_data
);
    import aatrm_pkg::*;

    localparam int MW = 2 * QW;
    localparam int TW = MW + 4;
    localparam logic signed [TW-1:0] ONE_Q48  = TW'(1) <<< 48;
    localparam logic signed [TW-1:0] HALF_LSB = TW'(1) <<< 33;
    localparam logic signed [TW-1:0] SAT_HI   = TW'(32767);
    localparam logic signed [TW-1:0] SAT_LO   = -TW'(32768);

    // product order: xx yy zz xy xz yz wx wy wz
    localparam int P_XX = 0;
    localparam int P_YY = 1;
    localparam int P_ZZ = 2;
    localparam int P_XY = 3;
    localparam int P_XZ = 4;
    localparam int P_YZ = 5;
    localparam int P_WX = 6;
    localparam int P_WY = 7;
    localparam int P_WZ = 8;

    logic r_vld_p;
    logic r_vld_t;
    logic r_vld_o;
    logic adv_p;
    logic adv_t;
    logic adv_o;

    logic signed [MW-1:0] r_p [9];
    logic signed [TW-1:0] r_t [9];
    t_mat                 r_m;

    logic signed [MW-1:0] n_p [9];
    logic signed [TW-1:0] n_t [9];
    logic signed [TW-1:0] e   [9];
    t_mat                 n_m;

    function automatic logic signed [TW-1:0] ext(input logic signed [MW-1:0] v);
        return TW'(v);
    endfunction

    assign adv_o   = !r_vld_o || i_ready;
    assign adv_t   = !r_vld_t || adv_o;
    assign adv_p   = !r_vld_p || adv_t;
    assign o_ready = adv_p;
    assign o_valid = r_vld_o;
    assign o_data  = r_m;

    always_comb begin
        n_p[P_XX] = MW'(i_data.x) * MW'(i_data.x);
        n_p[P_YY] = MW'(i_data.y) * MW'(i_data.y);
        n_p[P_ZZ] = MW'(i_data.z) * MW'(i_data.z);
        n_p[P_XY] = MW'(i_data.x) * MW'(i_data.y);
        n_p[P_XZ] = MW'(i_data.x) * MW'(i_data.z);
        n_p[P_YZ] = MW'(i_data.y) * MW'(i_data.z);
        n_p[P_WX] = MW'(i_data.w) * MW'(i_data.x);
        n_p[P_WY] = MW'(i_data.w) * MW'(i_data.y);
        n_p[P_WZ] = MW'(i_data.w) * MW'(i_data.z);
    end

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            e[k] = ext(r_p[k]);
        end
        n_t[0] = ONE_Q48 - ((e[P_YY] + e[P_ZZ]) <<< 1);
        n_t[1] = (e[P_XY] - e[P_WZ]) <<< 1;
        n_t[2] = (e[P_XZ] + e[P_WY]) <<< 1;
        n_t[3] = (e[P_XY] + e[P_WZ]) <<< 1;
        n_t[4] = ONE_Q48 - ((e[P_XX] + e[P_ZZ]) <<< 1);
        n_t[5] = (e[P_YZ] - e[P_WX]) <<< 1;
        n_t[6] = (e[P_XZ] - e[P_WY]) <<< 1;
        n_t[7] = (e[P_YZ] + e[P_WX]) <<< 1;
        n_t[8] = ONE_Q48 - ((e[P_XX] + e[P_YY]) <<< 1);
    end

    // round half up from Q48 to Q14, then clamp to the field range
    always_comb begin
        logic signed [TW-1:0] r;
        for (int k = 0; k < 9; k++) begin
            r = (r_t[k] + HALF_LSB) >>> 34;
            if (r > SAT_HI) begin
                n_m[k] = FW'(SAT_HI);
            end else if (r < SAT_LO) begin
                n_m[k] = FW'(SAT_LO);
            end else begin
                n_m[k] = FW'(r);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_p <= 1'b0;
            r_vld_t <= 1'b0;
            r_vld_o <= 1'b0;
        end else begin
            if (adv_p) begin
                r_vld_p <= i_valid;
            end
            if (adv_t) begin
                r_vld_t <= r_vld_p;
            end
            if (adv_o) begin
                r_vld_o <= r_vld_t;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_p && i_valid) begin
            r_p <= n_p;
        end
        if (adv_t && r_vld_p) begin
            r_t <= n_t;
        end
        if (adv_o && r_vld_t) begin
            r_m <= n_m;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/axis_angle_to_rotation_matrix.sv
// Pipeline: a register in each CORDIC cell, then the quaternion forming stages,
// then the matrix product, sum and rounding stages.
// Throughput: one request per cycle unless stalled; every stage holds its own
// valid bit, so a stalled output only stops the stages behind it once they fill up.
// Reset: synchronous, active low; clears all valid bits, the data path is not reset.
`default_nettype none
module axis_angle_to_rotation_matrix (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // rot_angle, axis_x, axis_y, axis_z
    input  wire logic [4*aatrm_pkg::FW-1:0] i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  wire logic                       i_m_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22
    output logic [9*aatrm_pkg::FW-1:0]      o_m_axis_tdata
);
    import aatrm_pkg::*;

    t_cordic c_data  [N_STAGES+1];
    logic    c_valid [N_STAGES+1];
    logic    c_ready [N_STAGES+1];

    logic  q_valid;
    logic  q_ready;
    t_quat q_data;
    t_mat  m_data;

    always_comb begin
        c_data[0].x  = GAIN_Q30;
        c_data[0].y  = '0;
        c_data[0].z  = ZW'($signed(i_s_axis_tdata[FW-1:0])) <<< 15;
        c_data[0].ax = i_s_axis_tdata[2*FW-1:FW];
        c_data[0].ay = i_s_axis_tdata[3*FW-1:2*FW];
        c_data[0].az = i_s_axis_tdata[4*FW-1:3*FW];
    end

    assign c_valid[0]      = i_s_axis_tvalid;
    assign o_s_axis_tready = c_ready[0];

    for (genvar k = 0; k < N_STAGES; k++) begin : g_cell
        aatrm_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (SHIFT_W'(k)),
            .i_atan  (ATAN_TBL[k]),
            .i_valid (c_valid[k]),
            .o_ready (c_ready[k]),
            .i_data  (c_data[k]),
            .o_valid (c_valid[k+1]),
            .i_ready (c_ready[k+1]),
            .o_data  (c_data[k+1])
        );
    end

    aatrm_quat u_quat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (c_valid[N_STAGES]),
        .o_ready (c_ready[N_STAGES]),
        .i_data  (c_data[N_STAGES]),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_data)
    );

    aatrm_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_data  (q_data),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (m_data)
    );

    assign o_m_axis_tdata = m_data;

`ifndef SYNTHESIS
    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input blocked while output stage is empty");

    a_block_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid && !i_m_axis_tready)
        else $error("input blocked without an output stall");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");
`endif

endmodule
`default_nettype wire

FILE: bench/rotation_matrix_checker.sv
// Watches both streams of the rotation matrix block, predicts each matrix and compares it.
`default_nettype none
module rotation_matrix_checker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_req_valid,
    input  wire logic                       i_req_ready,
    // rot_angle, axis_x, axis_y, axis_z
    input  wire logic [4*aatrm_pkg::FW-1:0] i_req_data,
    input  wire logic                       i_mat_valid,
    input  wire logic                       i_mat_ready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22
    input  wire logic [9*aatrm_pkg::FW-1:0] i_mat_data,
    output int                              o_fail_count,
    output int                              o_pending
);

    localparam int     CORDIC_DEPTH = 14;
    localparam longint CORDIC_GAIN  = 652032874;     // inverse CORDIC gain, Q30
    localparam longint ONE_Q48      = longint'(1) << 48;

    // atan(2^-i), 2^32 per turn
    localparam longint ARCTAN_TURNS [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838,  5340245,   2670163,   1335087,  667544,   333772,
        166886,    83443,     41722,     20861,    10430,    5215,
        2608,      1304,      652,       326,      163,      81
    };

    string entry_names [9] = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};

    aatrm_pkg::t_mat expected_matrices [$];
    aatrm_pkg::t_mat want;
    aatrm_pkg::t_mat got;
    int              mismatches = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic longint round_half_up(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic logic [15:0] q48_to_q14(input longint v);
        longint r;
        r = round_half_up(v, 34);
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[15:0];
    endfunction

    function automatic aatrm_pkg::t_mat predict_rotation(input logic [63:0] req);
        longint          angle, ax, ay, az;
        longint          cx, cy, cz, dx, dy;
        longint          w, qx, qy, qz;
        longint          terms [9];
        aatrm_pkg::t_mat mat;
        int              k;
        angle = longint'($signed(req[15:0]));
        ax    = longint'($signed(req[31:16]));
        ay    = longint'($signed(req[47:32]));
        az    = longint'($signed(req[63:48]));
        // half angle: full turn of 2^16 scaled to 2^32, then halved
        cx = CORDIC_GAIN;
        cy = 0;
        cz = angle * 32768;
        for (k = 0; k < CORDIC_DEPTH; k++) begin
            dx = cy >>> k;
            dy = cx >>> k;
            if (cz >= 0) begin
                cx = cx - dx;
                cy = cy + dy;
                cz = cz - ARCTAN_TURNS[k];
            end else begin
                cx = cx + dx;
                cy = cy - dy;
                cz = cz + ARCTAN_TURNS[k];
            end
        end
        // quaternion in Q24
        w  = round_half_up(cx, 6);
        qx = round_half_up(cy * ax, 20);
        qy = round_half_up(cy * ay, 20);
        qz = round_half_up(cy * az, 20);
        terms[0] = ONE_Q48 - 2 * (qy * qy + qz * qz);
        terms[1] = 2 * (qx * qy - w * qz);
        terms[2] = 2 * (qx * qz + w * qy);
        terms[3] = 2 * (qx * qy + w * qz);
        terms[4] = ONE_Q48 - 2 * (qx * qx + qz * qz);
        terms[5] = 2 * (qy * qz - w * qx);
        terms[6] = 2 * (qx * qz - w * qy);
        terms[7] = 2 * (qy * qz + w * qx);
        terms[8] = ONE_Q48 - 2 * (qx * qx + qy * qy);
        for (k = 0; k < 9; k++)
            mat[k] = q48_to_q14(terms[k]);
        return mat;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_req_valid && i_req_ready)
                expected_matrices.push_back(predict_rotation(i_req_data));
            if (i_mat_valid && i_mat_ready) begin
                got = i_mat_data;
                if (expected_matrices.size() == 0) begin
                    $error("matrix out with no request outstanding");
                    mismatches++;
                end else begin
                    want = expected_matrices.pop_front();
                    for (int k = 0; k < 9; k++) begin
                        if (got[k] !== want[k]) begin
                            $error("%s: expected %0d, got %0d", entry_names[k],
                                   $signed(want[k]), $signed(got[k]));
                            mismatches++;
                        end
                    end
                end
            end
        end
        o_pending    <= expected_matrices.size();
        o_fail_count <= mismatches;
    end

endmodule
`default_nettype wire

FILE: bench/testbench.sv
// Stimulus, flow control and verdict for the axis-angle to rotation matrix block.
`default_nettype none
module testbench;

    localparam int IDLE_LIMIT  = 2000;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_WAIT  = 40;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic        req_valid = 1'b0;
    logic        req_ready;
    logic [63:0] req_data  = '0;     // rot_angle, axis_x, axis_y, axis_z
    logic        mat_valid;
    logic        mat_ready = 1'b0;
    logic [143:0] mat_data;          // m00 .. m22, row by row

    int fail_count;
    int pending;
    int idle_cycles = 0;

    bit tx_idle_en  = 1'b1;
    bit rx_idle_en  = 1'b1;
    bit rx_hold_req = 1'b0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    axis_angle_to_rotation_matrix i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (req_valid),
        .o_s_axis_tready (req_ready),
        .i_s_axis_tdata  (req_data),
        .o_m_axis_tvalid (mat_valid),
        .i_m_axis_tready (mat_ready),
        .o_m_axis_tdata  (mat_data)
    );

    rotation_matrix_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req_ready  (req_ready),
        .i_req_data   (req_data),
        .i_mat_valid  (mat_valid),
        .i_mat_ready  (mat_ready),
        .i_mat_data   (mat_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // mostly short gaps, now and then a long one
    function automatic int idle_length();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [63:0] pack_request(input int angle, input int ax,
                                                 input int ay, input int az);
        return {16'(az), 16'(ay), 16'(ax), 16'(angle)};
    endfunction

    function automatic logic [63:0] random_request();
        logic [15:0] angle;
        int          ax, ay, az;
        real         vx, vy, vz, norm;
        angle = 16'($urandom);
        if ($urandom_range(0, 19) == 0)
            angle = ($urandom_range(0, 1) == 1) ? 16'h8000 : 16'h7fff;
        vx = real'(int'($urandom_range(0, 32768)) - 16384);
        vy = real'(int'($urandom_range(0, 32768)) - 16384);
        vz = real'(int'($urandom_range(0, 32768)) - 16384);
        if ($urandom_range(0, 9) < 7) begin
            // unit axis with random direction
            norm = $sqrt(vx * vx + vy * vy + vz * vz);
            if (norm < 1.0) begin
                ax = 16384;
                ay = 0;
                az = 0;
            end else begin
                ax = $rtoi(vx * 16384.0 / norm);
                ay = $rtoi(vy * 16384.0 / norm);
                az = $rtoi(vz * 16384.0 / norm);
            end
        end else begin
            ax = $rtoi(vx);
            ay = $rtoi(vy);
            az = $rtoi(vz);
        end
        return {16'(az), 16'(ay), 16'(ax), angle};
    endfunction

    task automatic send_request(input logic [63:0] data);
        int gap;
        gap = 0;
        if (tx_idle_en && $urandom_range(0, 2) == 0)
            gap = idle_length();
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= data;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic send_random(input int count);
        repeat (count)
            send_request(random_request());
    endtask

    // receiver: random stalls, plus one long hold on request
    initial begin
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            if (rx_hold_req) begin
                mat_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                rx_hold_req = 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
                mat_ready <= 1'b0;
                repeat (idle_length()) @(posedge clk);
            end else begin
                mat_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((req_valid && req_ready) || (mat_valid && mat_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: angle extremes, principal axes, non-unit and zero axes
        send_request(pack_request(0,      16384,  0,      0));
        send_request(pack_request(32767,  16384,  0,      0));
        send_request(pack_request(-32768, 16384,  0,      0));
        send_request(pack_request(16384,  0,      16384,  0));
        send_request(pack_request(-16384, 0,      16384,  0));
        send_request(pack_request(8192,   0,      0,      16384));
        send_request(pack_request(-8192,  0,      0,      -16384));
        send_request(pack_request(32767,  -16384, 0,      0));
        send_request(pack_request(-32768, 0,      -16384, 0));
        send_request(pack_request(-32768, 0,      0,      16384));
        send_request(pack_request(32767,  16384,  16384,  16384));
        send_request(pack_request(-32768, 16384,  16384,  16384));
        send_request(pack_request(16384,  -16384, -16384, -16384));
        send_request(pack_request(-16384, 16384,  -16384, 16384));
        send_request(pack_request(32767,  0,      0,      0));
        send_request(pack_request(0,      0,      0,      0));
        send_request(pack_request(1,      9459,   9459,   9459));
        send_request(pack_request(-1,     -9459,  9459,   -9459));
        send_request(pack_request(10923,  11585,  11585,  0));
        send_request(pack_request(-21845, 0,      -11585, 11585));
        send_request(pack_request(24576,  -16384, 16384,  0));
        send_request(pack_request(5461,   16384,  -1,     1));
        send_request(pack_request(-5461,  1,      16384,  -1));
        send_request(pack_request(12345,  16383,  -16383, 16383));
        send_request(pack_request(-32767, -1,     -1,     -1));
        drain();

        send_random(200);

        // receiver holds off while the sender keeps offering: pipeline fills
        tx_idle_en  = 1'b0;
        rx_hold_req = 1'b1;
        send_random(80);
        drain();

        // full rate on both sides
        rx_idle_en = 1'b0;
        send_random(150);
        drain();

        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        send_random(220);
        drain();

        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire

FILE: sim.f
rtl/aatrm_pkg.sv
rtl/aatrm_cordic_cell.sv
rtl/aatrm_quat.sv
rtl/aatrm_matrix.sv
rtl/axis_angle_to_rotation_matrix.sv
bench/rotation_matrix_checker.sv
bench/testbench.sv
